>>> hdl/ring_buffer_deque_macros.svh
// Assertion macros for the ring buffer deque.
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH
`ifndef SYNTHESIS
`define RBD_ASSERT_HOLDS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("rbd: invariant violated");
`define RBD_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("rbd: next-cycle check violated");
`else
`define RBD_ASSERT_HOLDS(label, cond)
`define RBD_ASSERT_NEXT(label, trig, cond)
`endif
`endif

>>> hdl/rbd_pkg.sv
// Shared types and codes for the ring buffer deque.
package rbd_pkg;

   localparam int DEPTH      = 16;
   localparam int WORD_BITS  = 32;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                op;
      logic [WORD_BITS-1:0]  push_word;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]  pop_word;
      status_type            status;
      logic [COUNT_BITS-1:0] count;
   } rsp_type;

   typedef struct packed {
      logic shift_right;
      logic shift_left;
      logic load_back;
      logic drop_back;
   } cell_ctrl_type;

endpackage

>>> hdl/rbd_cell.sv
// One deque cell: holds one entry and its occupancy flag, shifts with its neighbors.
module rbd_cell #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rbd_pkg::cell_ctrl_type ctrl,
   input  logic [WORD_WIDTH-1:0]  push_word,
   input  logic [WORD_WIDTH-1:0]  left_word,
   input  logic                   left_occ,
   input  logic [WORD_WIDTH-1:0]  right_word,
   input  logic                   right_occ,
   output logic [WORD_WIDTH-1:0]  word,
   output logic                   occ,
   output logic [WORD_WIDTH-1:0]  tail_word
);

   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic                  occ_ff, occ_in;

   always_comb begin
      word_in = word_ff;
      occ_in  = occ_ff;
      if (ctrl.shift_right) begin
         word_in = left_word;
         occ_in  = left_occ;
      end else if (ctrl.shift_left) begin
         word_in = right_word;
         occ_in  = right_occ;
      end else if (ctrl.load_back && left_occ && !occ_ff) begin
         word_in = push_word;
         occ_in  = 1'b1;
      end else if (ctrl.drop_back && occ_ff && !right_occ) begin
         occ_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      word_ff <= word_in;
   end

   assign word      = word_ff;
   assign occ       = occ_ff;
   // last occupied cell offers its entry for a pop at the back
   assign tail_word = (occ_ff && !right_occ) ? word_ff : '0;

endmodule

>>> hdl/ring_buffer_deque.sv
// Ring buffer deque top level: control, cell row and result register.
// A double-ended queue of DEPTH words held in a row of cells, front entry in
// cell 0. Push front and pop front shift the whole row by one cell; push back
// fills the first free cell; pop back takes the last occupied cell. Every
// item gives one result (popped word, status, count after the operation) in the
// cycle after it is accepted, and a new item is taken every cycle while the
// result register is free or being drained, so the rate is one item per
// cycle. After reset the deque is empty at once; no clearing pass is needed.
`include "ring_buffer_deque_macros.svh"
module ring_buffer_deque (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rbd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rbd_pkg::rsp_type rsp_payload
);

   localparam int DEPTH      = rbd_pkg::DEPTH;
   localparam int WORD_WIDTH = rbd_pkg::WORD_BITS;
   localparam int CW         = rbd_pkg::COUNT_BITS;

   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rbd_pkg::rsp_type       rsp_ff, rsp_in;
   rbd_pkg::cell_ctrl_type ctrl;
   rbd_pkg::status_type    status;
   logic                   req_fire, full, empty, push_ok;
   logic [WORD_WIDTH-1:0]  push_w, pop_w, tail_or;
   logic [WORD_WIDTH-1:0]  cell_word [DEPTH];
   logic [WORD_WIDTH-1:0]  cell_tail [DEPTH];
   logic [DEPTH-1:0]       cell_occ;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = count_ff == CW'(DEPTH);
   assign empty     = count_ff == '0;
   assign push_w    = WORD_WIDTH'(req_payload.push_word);

   always_comb begin
      tail_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_or = tail_or | cell_tail[i];
      end
   end

   always_comb begin
      ctrl     = '0;
      status   = rbd_pkg::ST_OK;
      count_in = count_ff;
      pop_w    = '0;
      push_ok  = 1'b0;
      unique case (req_payload.op)
         rbd_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               status = rbd_pkg::ST_FULL;
            end else begin
               ctrl.shift_right = req_fire;
               push_ok          = 1'b1;
               count_in         = count_ff + CW'(1);
            end
         end
         rbd_pkg::OP_PUSH_BACK: begin
            if (full) begin
               status = rbd_pkg::ST_FULL;
            end else begin
               ctrl.load_back = req_fire;
               push_ok        = 1'b1;
               count_in       = count_ff + CW'(1);
            end
         end
         rbd_pkg::OP_POP_FRONT: begin
            if (empty) begin
               status = rbd_pkg::ST_EMPTY;
            end else begin
               ctrl.shift_left = req_fire;
               pop_w           = cell_word[0];
               count_in        = count_ff - CW'(1);
            end
         end
         rbd_pkg::OP_POP_BACK: begin
            if (empty) begin
               status = rbd_pkg::ST_EMPTY;
            end else begin
               ctrl.drop_back = req_fire;
               pop_w          = tail_or;
               count_in       = count_ff - CW'(1);
            end
         end
      endcase
      rsp_in.pop_word = rbd_pkg::WORD_BITS'(pop_w);
      rsp_in.status   = status;
      rsp_in.count    = rbd_pkg::COUNT_BITS'(count_in);
      rsp_valid_in    = req_fire || (rsp_valid_ff && !rsp_ready);
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] left_word, right_word;
      logic                  left_occ, right_occ;
      if (i == 0) begin : g_head
         assign left_word = push_w;
         assign left_occ  = 1'b1;
      end else begin : g_mid_l
         assign left_word = cell_word[i-1];
         assign left_occ  = cell_occ[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_word = '0;
         assign right_occ  = 1'b0;
      end else begin : g_mid_r
         assign right_word = cell_word[i+1];
         assign right_occ  = cell_occ[i+1];
      end
      rbd_cell #(
         .WORD_WIDTH(WORD_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .push_word  (push_w),
         .left_word  (left_word),
         .left_occ   (left_occ),
         .right_word (right_word),
         .right_occ  (right_occ),
         .word       (cell_word[i]),
         .occ        (cell_occ[i]),
         .tail_word  (cell_tail[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `RBD_ASSERT_HOLDS(a_occ_matches_count, cell_occ[0] == (count_ff != '0))
   `RBD_ASSERT_HOLDS(a_full_matches_occ, cell_occ[DEPTH-1] == full)
   `RBD_ASSERT_NEXT(a_push_grows, req_fire && push_ok, count_ff == $past(count_ff) + CW'(1))
   `RBD_ASSERT_NEXT(a_fire_gives_rsp, req_fire, rsp_valid_ff)

endmodule
